// ----- rtl/core/abms_pkg.sv -----
// Package for the burst memory slave: sizes, codes, request structs and the
// range check. No dependencies; every other file of the block imports it.
`default_nettype none
package abms_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int BUS_BYTES = 8;
  localparam int MAX_BEATS = 64;

  localparam int ADDR_W   = 32;
  localparam int ID_W     = 8;
  localparam int DATA_W   = 64;
  localparam int STRB_W   = 8;
  localparam int LIMIT_W  = 17;
  localparam int BYTES_W  = 4;
  localparam int BEATS_W  = 7;
  localparam int COUNT_W  = 6;

  localparam int LANES     = BUS_BYTES;
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROW_DEPTH = MEM_BYTES / LANES;
  localparam int ROW_W     = $clog2(ROW_DEPTH);

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WREQ  = 2'd1,
    MODE_WBEAT = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic KIND_RDATA = 1'b0;
  localparam logic KIND_WRESP = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
    logic [STRB_W-1:0]  strobe;
    logic [DATA_W-1:0]  data;
  } wr_req_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] bytes;
  } rd_req_t;

  // True when the whole beat lies below the effective limit, computed without wrap.
  function automatic logic beat_in_range(logic [ADDR_W-1:0] a, logic [BYTES_W-1:0] n,
                                         logic [LIMIT_W-1:0] lim);
    logic [ADDR_W:0]    sum;
    logic [LIMIT_W-1:0] eff;
    sum = {1'b0, a} + {{(ADDR_W+1-BYTES_W){1'b0}}, n};
    eff = (lim > LIMIT_W'(MEM_BYTES)) ? LIMIT_W'(MEM_BYTES) : lim;
    return sum <= {{(ADDR_W+1-LIMIT_W){1'b0}}, eff};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/abms_lane_ram.sv -----
// One byte lane of the memory: a synchronous RAM with one write and one read port.
// Depends on abms_pkg for the row count.
`default_nettype none
module abms_lane_ram
  import abms_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [ROW_W-1:0] waddr,
  input  wire logic [7:0]       wdata,
  input  wire logic             re,
  input  wire logic [ROW_W-1:0] raddr,
  output logic      [7:0]       rdata
);

  logic [7:0] mem [ROW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/abms_mem.sv -----
// Byte memory built from one RAM per bus lane, with the lane rotation for
// unaligned writes and reads. Depends on abms_pkg and abms_lane_ram.
`default_nettype none
module abms_mem
  import abms_pkg::*;
(
  input  wire logic              clk,
  input  wire wr_req_t           wr,
  input  wire rd_req_t           rd,
  output logic      [DATA_W-1:0] rd_data
);

  logic [7:0]         lane_q [LANES];
  logic [LANE_W-1:0]  rd_shift_r;
  logic [BYTES_W-1:0] rd_bytes_r;

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_shift_r <= rd.addr[LANE_W-1:0];
      rd_bytes_r <= rd.bytes;
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    localparam logic [LANE_W-1:0] LJ = LANE_W'(j);
    logic [LANE_W-1:0] wr_idx;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [ROW_W-1:0]  rd_row;

    assign wr_idx = LJ - wr.addr[LANE_W-1:0];
    assign wr_en  = wr.en && wr.strobe[wr_idx] && ({1'b0, wr_idx} < wr.bytes);
    assign wr_row = wr.addr[ROW_W+LANE_W-1:LANE_W]
                    + ROW_W'(LJ < wr.addr[LANE_W-1:0]);
    assign rd_row = rd.addr[ROW_W+LANE_W-1:LANE_W]
                    + ROW_W'(LJ < rd.addr[LANE_W-1:0]);

    abms_lane_ram u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_row),
      .wdata (wr.data[8*wr_idx +: 8]),
      .re    (rd.en),
      .raddr (rd_row),
      .rdata (lane_q[j])
    );
  end

  for (genvar i = 0; i < LANES; i++) begin : g_align
    localparam logic [LANE_W-1:0] LI = LANE_W'(i);
    logic [LANE_W-1:0] src;

    assign src = LI + rd_shift_r;
    assign rd_data[8*i +: 8] = ({1'b0, LI} < rd_bytes_r) ? lane_q[src] : 8'h00;
  end

  if (LANES * 8 < DATA_W) begin : g_pad
    assign rd_data[DATA_W-1:LANES*8] = '0;
  end

endmodule
`default_nettype wire

// ----- rtl/core/abms_ctrl.sv -----
// Control of the burst memory slave: limit register, open write burst, read
// beat sequencer and the result register. Depends on abms_pkg.
`default_nettype none
module abms_ctrl
  import abms_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_mode,
  input  wire logic [ADDR_W-1:0]   in_address,
  input  wire logic [ID_W-1:0]     in_txn_id,
  input  wire logic [1:0]          in_beat_size_log2,
  input  wire logic [COUNT_W-1:0]  in_beat_count_minus_one,
  input  wire logic [STRB_W-1:0]   in_write_strobe,
  input  wire logic [DATA_W-1:0]   in_write_data,
  input  wire logic                in_write_last,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_wdata,
  output wr_req_t                  wr,
  output rd_req_t                  rd,
  input  wire logic [DATA_W-1:0]   mem_rd_data,
  output logic                     out_valid,
  output logic                     out_kind,
  output logic      [ID_W-1:0]     out_resp_id,
  output logic      [DATA_W-1:0]   out_read_data,
  output logic                     out_last,
  output logic                     out_fault
);

  state_t             state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r;

  logic [ADDR_W-1:0]  burst_addr_r, burst_addr_nxt;
  logic [BYTES_W-1:0] burst_bytes_r, burst_bytes_nxt;
  logic [ID_W-1:0]    burst_id_r, burst_id_nxt;
  logic               burst_open_r, burst_open_nxt;
  logic [BEATS_W-1:0] beats_rem_r, beats_rem_nxt;
  logic               burst_err_r, burst_err_nxt;

  logic [ADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [BYTES_W-1:0] rd_bytes_r, rd_bytes_nxt;
  logic [BEATS_W-1:0] rd_left_r, rd_left_nxt;
  logic [ID_W-1:0]    rd_id_r, rd_id_nxt;
  logic               rd_shape_r, rd_shape_nxt;

  logic               p1_valid_r, p1_valid_nxt;
  logic               p1_last_r, p1_last_nxt;
  logic               p1_ok_r, p1_ok_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_fault_r, out_fault_nxt;

  logic               accept;
  logic [BYTES_W-1:0] req_bytes;
  logic [BEATS_W-1:0] req_beats;
  logic               shape_fault;
  logic               wr_ok;
  logic [BEATS_W-1:0] rem_dec;
  logic               final_beat;
  logic               err_beat;

  assign busy   = (state_r != ST_IDLE) || p1_valid_r;
  assign accept = start && !busy;

  always_comb begin
    req_bytes   = BYTES_W'(1) << in_beat_size_log2;
    req_beats   = BEATS_W'(in_beat_count_minus_one) + BEATS_W'(1);
    shape_fault = 1'b0;
    if (req_bytes > BYTES_W'(BUS_BYTES)) begin
      req_bytes   = BYTES_W'(BUS_BYTES);
      shape_fault = 1'b1;
    end
    if (req_beats > BEATS_W'(MAX_BEATS)) begin
      req_beats   = BEATS_W'(MAX_BEATS);
      shape_fault = 1'b1;
    end
  end

  assign wr_ok      = beat_in_range(burst_addr_r, burst_bytes_r, limit_r);
  assign rem_dec    = (beats_rem_r != '0) ? beats_rem_r - BEATS_W'(1) : beats_rem_r;
  assign final_beat = (rem_dec == '0);
  assign err_beat   = burst_err_r || !wr_ok || (in_write_last != final_beat);

  always_comb begin
    state_nxt       = state_r;
    burst_addr_nxt  = burst_addr_r;
    burst_bytes_nxt = burst_bytes_r;
    burst_id_nxt    = burst_id_r;
    burst_open_nxt  = burst_open_r;
    beats_rem_nxt   = beats_rem_r;
    burst_err_nxt   = burst_err_r;
    rd_addr_nxt     = rd_addr_r;
    rd_bytes_nxt    = rd_bytes_r;
    rd_left_nxt     = rd_left_r;
    rd_id_nxt       = rd_id_r;
    rd_shape_nxt    = rd_shape_r;
    p1_valid_nxt    = 1'b0;
    p1_last_nxt     = p1_last_r;
    p1_ok_nxt       = p1_ok_r;
    out_valid_nxt   = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_id_nxt      = out_id_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    out_fault_nxt   = out_fault_r;

    wr        = '0;
    wr.addr   = burst_addr_r;
    wr.bytes  = burst_bytes_r;
    wr.strobe = in_write_strobe;
    wr.data   = in_write_data;
    rd        = '0;
    rd.addr   = rd_addr_r;
    rd.bytes  = rd_bytes_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode_t'(in_mode))
            MODE_READ: begin
              rd_addr_nxt  = in_address;
              rd_bytes_nxt = req_bytes;
              rd_left_nxt  = req_beats;
              rd_id_nxt    = in_txn_id;
              rd_shape_nxt = shape_fault;
              state_nxt    = ST_READ;
            end
            MODE_WREQ: begin
              if (burst_open_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_WRESP;
                out_id_nxt    = in_txn_id;
                out_data_nxt  = '0;
                out_last_nxt  = 1'b1;
                out_fault_nxt = 1'b1;
              end else begin
                burst_addr_nxt  = in_address;
                burst_bytes_nxt = req_bytes;
                burst_id_nxt    = in_txn_id;
                burst_open_nxt  = 1'b1;
                beats_rem_nxt   = req_beats;
                burst_err_nxt   = shape_fault;
              end
            end
            MODE_WBEAT: begin
              if (!burst_open_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_WRESP;
                out_id_nxt    = in_txn_id;
                out_data_nxt  = '0;
                out_last_nxt  = 1'b1;
                out_fault_nxt = 1'b1;
              end else begin
                wr.en          = wr_ok;
                burst_addr_nxt = burst_addr_r + ADDR_W'(burst_bytes_r);
                beats_rem_nxt  = rem_dec;
                if (final_beat) begin
                  burst_open_nxt = 1'b0;
                  burst_err_nxt  = 1'b0;
                  out_valid_nxt  = 1'b1;
                  out_kind_nxt   = KIND_WRESP;
                  out_id_nxt     = burst_id_r;
                  out_data_nxt   = '0;
                  out_last_nxt   = 1'b1;
                  out_fault_nxt  = err_beat;
                end else begin
                  burst_err_nxt = err_beat;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        rd.en        = 1'b1;
        p1_valid_nxt = 1'b1;
        p1_last_nxt  = (rd_left_r == BEATS_W'(1));
        p1_ok_nxt    = beat_in_range(rd_addr_r, rd_bytes_r, limit_r);
        rd_addr_nxt  = rd_addr_r + ADDR_W'(rd_bytes_r);
        rd_left_nxt  = rd_left_r - BEATS_W'(1);
        if (rd_left_r == BEATS_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (p1_valid_r) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_RDATA;
      out_id_nxt    = rd_id_r;
      out_data_nxt  = p1_ok_r ? mem_rd_data : '0;
      out_last_nxt  = p1_last_r;
      out_fault_nxt = rd_shape_r || !p1_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      limit_r       <= LIMIT_W'(MEM_BYTES);
      burst_addr_r  <= '0;
      burst_bytes_r <= '0;
      burst_id_r    <= '0;
      burst_open_r  <= 1'b0;
      beats_rem_r   <= '0;
      burst_err_r   <= 1'b0;
      rd_left_r     <= '0;
      p1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      burst_addr_r  <= burst_addr_nxt;
      burst_bytes_r <= burst_bytes_nxt;
      burst_id_r    <= burst_id_nxt;
      burst_open_r  <= burst_open_nxt;
      beats_rem_r   <= beats_rem_nxt;
      burst_err_r   <= burst_err_nxt;
      rd_left_r     <= rd_left_nxt;
      p1_valid_r    <= p1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    rd_bytes_r  <= rd_bytes_nxt;
    rd_id_r     <= rd_id_nxt;
    rd_shape_r  <= rd_shape_nxt;
    p1_last_r   <= p1_last_nxt;
    p1_ok_r     <= p1_ok_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_resp_id   = out_id_r;
  assign out_read_data = out_data_r;
  assign out_last      = out_last_r;
  assign out_fault     = out_fault_r;

endmodule
`default_nettype wire

// ----- rtl/core/axi_burst_memory_slave_top.sv -----
// Top level of the burst memory slave: control and the lane-organized byte memory.
// Depends on abms_pkg, abms_ctrl and abms_mem.
//
// A write request or a write data beat is taken without raising busy, so busy stays low and
// one word can be offered every cycle; a write response appears on the result ports
// in the cycle after the beat that closes the burst. A read request keeps busy high
// while the sequencer issues its beats and while the memory reads the last one, and no
// word is taken before busy falls: the sequencer issues one beat per cycle to the memory,
// whose registered read feeds the result register. Read beats leave on consecutive cycles, each on
// the result ports for one cycle only; the receiver must take every word as it comes.
// The memory needs no clearing after reset and a byte must be written before it is read.
`default_nettype none
module axi_burst_memory_slave_top
  import abms_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_mode,
  input  wire logic [ADDR_W-1:0]   in_address,
  input  wire logic [ID_W-1:0]     in_txn_id,
  input  wire logic [1:0]          in_beat_size_log2,
  input  wire logic [COUNT_W-1:0]  in_beat_count_minus_one,
  input  wire logic [STRB_W-1:0]   in_write_strobe,
  input  wire logic [DATA_W-1:0]   in_write_data,
  input  wire logic                in_write_last,
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_wdata,
  output logic                     out_valid,
  output logic                     out_kind,
  output logic      [ID_W-1:0]     out_resp_id,
  output logic      [DATA_W-1:0]   out_read_data,
  output logic                     out_last,
  output logic                     out_fault
);

  wr_req_t           wr;
  rd_req_t           rd;
  logic [DATA_W-1:0] mem_rd_data;

  abms_ctrl u_ctrl (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_mode                 (in_mode),
    .in_address              (in_address),
    .in_txn_id               (in_txn_id),
    .in_beat_size_log2       (in_beat_size_log2),
    .in_beat_count_minus_one (in_beat_count_minus_one),
    .in_write_strobe         (in_write_strobe),
    .in_write_data           (in_write_data),
    .in_write_last           (in_write_last),
    .cfg_we                  (cfg_we),
    .cfg_wdata               (cfg_wdata),
    .wr                      (wr),
    .rd                      (rd),
    .mem_rd_data             (mem_rd_data),
    .out_valid               (out_valid),
    .out_kind                (out_kind),
    .out_resp_id             (out_resp_id),
    .out_read_data           (out_read_data),
    .out_last                (out_last),
    .out_fault               (out_fault)
  );

  abms_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (mem_rd_data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/abms_checker.sv -----
// Port-level checks of the burst memory slave and the bind that attaches them.
// Depends on abms_pkg and axi_burst_memory_slave_top.
`default_nettype none
module abms_checker
  import abms_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [1:0]          in_mode,
  input wire logic                out_valid,
  input wire logic                out_kind,
  input wire logic [ID_W-1:0]     out_resp_id,
  input wire logic [DATA_W-1:0]   out_read_data,
  input wire logic                out_last
);

  a_wresp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WRESP |-> out_last)
    else $error("write response without last");

  a_wresp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_WRESP |-> out_read_data == '0)
    else $error("write response carries data");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_READ |=> busy)
    else $error("read request did not raise busy");

  a_read_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_RDATA && !out_last
    |=> out_valid && out_kind == KIND_RDATA && $stable(out_resp_id))
    else $error("read burst interrupted");

endmodule

bind axi_burst_memory_slave_top abms_checker u_abms_checker (.*);
`default_nettype wire
